// File: src/fee_pkg.sv
// Package for the flat expression evaluator: item structs, operator,
// pending-operation and error codes, and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fee_pkg;

  // One input item: an operand and the operator that follows it.
  typedef struct packed {
    logic signed [31:0] operand;
    logic [2:0]         next_operator;
  } in_item_t;

  // One result item: the expression value and the first error raised.
  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         error;
  } out_item_t;

  // Operator codes. Every code from OP_END upward closes the expression.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_END = 3'd4;

  // Multiplicative operation waiting for the next operand.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_MUL  = 2'd1;
  localparam logic [1:0] PEND_DIV  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Limits of the 32-bit result field.
  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture an accepted input item
    logic setup;  // prepare the multiply/divide unit or take the operand as the term
    logic iter;   // one step of the shift-add multiplier or restoring divider
    logic sat;    // saturate the unit's magnitude into the term register
    logic route;  // fold the term into the product or the running sum
    logic emit;   // load the output register and clear the expression state
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_iter;  // the waiting operation uses the iterative unit
    logic iter_last;   // the current step is the last one
    logic op_product;  // the captured operator is multiply or divide
    logic op_end;      // the captured operator closes the expression
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/fee_datapath.sv
// Datapath of the flat expression evaluator: expression state, a shared
// add/subtract unit used bit-serially for multiply and divide, and the result register.
// Depends on fee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fee_datapath #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  fee_pkg::in_item_t   in_item,
  input  fee_pkg::dp_cmd_t    cmd,
  output fee_pkg::dp_status_t status,
  output fee_pkg::out_item_t  out_item
);
  import fee_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int NW   = WORD_BITS + FRAC_BITS;
  localparam int MAGW = 2 * WORD_BITS + FRAC_BITS;
  localparam int AW   = WORD_BITS + 2;
  localparam int CW   = $clog2(NW + 1);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  // Expression state.
  logic signed [W-1:0] running_sum;
  logic signed [W-1:0] product_term;
  logic                pending_sign;
  logic [1:0]          pending_op;
  logic [1:0]          error_seen;

  // Current item and the multiply/divide unit.
  logic signed [W-1:0] x_word;
  logic [2:0]          op_code;
  logic signed [W-1:0] term;
  logic [W-1:0]        hi;
  logic [NW-1:0]       lo;
  logic [W-1:0]        mcand;
  logic [CW-1:0]       count;
  logic                is_div;
  logic                neg;

  // Operand narrowed or widened to the word.
  logic signed [W-1:0] x_clamped;
  logic                x_ovf;

  if (W < 32) begin : g_in_narrow
    logic [32-W:0] top;
    assign top       = in_item.operand[31:W-1];
    assign x_ovf     = !((&top) || !(|top));
    assign x_clamped = x_ovf ? (in_item.operand[31] ? WMIN : WMAX)
                             : in_item.operand[W-1:0];
  end else begin : g_in_wide
    assign x_ovf     = 1'b0;
    assign x_clamped = W'($signed(in_item.operand));
  end

  // Final value narrowed to the 32-bit result field.
  logic signed [31:0] fin;
  logic               fin_ovf;

  if (W > 32) begin : g_out_wide
    logic [W-32:0] top;
    assign top     = running_sum[W-1:31];
    assign fin_ovf = !((&top) || !(|top));
    assign fin     = fin_ovf ? (running_sum[W-1] ? RES_MIN : RES_MAX)
                             : running_sum[31:0];
  end else begin : g_out_narrow
    assign fin_ovf = 1'b0;
    assign fin     = 32'($signed(running_sum));
  end

  // Magnitudes of the operand and of the product term.
  logic [W-1:0] mag_x;
  logic [W-1:0] mag_pt;
  assign mag_x  = x_word[W-1] ? $unsigned(-x_word) : $unsigned(x_word);
  assign mag_pt = product_term[W-1] ? $unsigned(-product_term) : $unsigned(product_term);

  // Operator classes of the captured item.
  logic op_product;
  logic op_end;
  assign op_product = (op_code == OP_MUL) || (op_code == OP_DIV);
  assign op_end     = (op_code >= OP_END);

  logic div_zero;
  assign div_zero = (pending_op == PEND_DIV) && (x_word == '0);

  assign status.needs_iter = (pending_op == PEND_MUL) ||
                             ((pending_op == PEND_DIV) && (x_word != '0));
  assign status.iter_last  = (count == CW'(1));
  assign status.op_product = op_product;
  assign status.op_end     = op_end;

  // Shared adder: a multiply step adds the multiplicand, a divide step
  // subtracts the divisor, and the term step adds or subtracts the term.
  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic [AW-1:0] add_sum;
  logic          add_sub;

  always_comb begin
    if (cmd.iter && is_div) begin
      add_a   = {1'b0, hi, lo[NW-1]};
      add_b   = {2'b00, mcand};
      add_sub = 1'b1;
    end else if (cmd.iter) begin
      add_a   = {2'b00, hi};
      add_b   = lo[0] ? {2'b00, mcand} : '0;
      add_sub = 1'b0;
    end else begin
      add_a   = {{2{running_sum[W-1]}}, running_sum};
      add_b   = {{2{term[W-1]}}, term};
      add_sub = pending_sign;
    end
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

  // One restoring-divide step: keep the difference when it is not negative.
  logic          div_ge;
  logic [W-1:0]  div_hi;
  assign div_ge = !add_sum[AW-1];
  assign div_hi = div_ge ? add_sum[W-1:0] : {hi[W-2:0], lo[NW-1]};

  // Saturation of the unit's magnitude into a signed word.
  logic [MAGW-1:0] mag_full;
  logic [MAGW-1:0] mag_res;
  logic [W-1:0]    mag_low;
  logic [W-1:0]    lim;
  logic            sat_ovf;
  logic signed [W-1:0] sat_val;

  assign mag_full = {hi, lo};
  assign mag_res  = is_div ? MAGW'(lo) : (mag_full >> (2 * FRAC_BITS));
  assign mag_low  = mag_res[W-1:0];
  assign lim      = neg ? LIM_NEG : LIM_POS;
  assign sat_ovf  = (|mag_res[MAGW-1:W]) || (mag_low > lim);
  assign sat_val  = sat_ovf ? (neg ? WMIN : WMAX)
                            : (neg ? $signed(-mag_low) : $signed(mag_low));

  // Running sum update with saturation.
  logic                sum_ovf;
  logic signed [W-1:0] sum_val;
  assign sum_ovf = (add_sum[W] != add_sum[W-1]);
  assign sum_val = sum_ovf ? (add_sum[AW-1] ? WMIN : WMAX) : add_sum[W-1:0];

  // Error raised in this cycle; only the first one of an expression is kept.
  logic [1:0] raise_code;
  always_comb begin
    priority if (cmd.load && x_ovf)                   raise_code = ERR_OVERFLOW;
    else if (cmd.setup && div_zero)                   raise_code = ERR_DIV_ZERO;
    else if (cmd.sat && sat_ovf)                      raise_code = ERR_OVERFLOW;
    else if (cmd.route && !op_product && sum_ovf)     raise_code = ERR_OVERFLOW;
    else                                              raise_code = ERR_NONE;
  end

  // Expression state.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      product_term <= '0;
      pending_sign <= 1'b0;
      pending_op   <= PEND_NONE;
      error_seen   <= ERR_NONE;
    end else if (cmd.emit) begin
      running_sum  <= '0;
      product_term <= '0;
      pending_sign <= 1'b0;
      pending_op   <= PEND_NONE;
      error_seen   <= ERR_NONE;
    end else begin
      if (error_seen == ERR_NONE) begin
        error_seen <= raise_code;
      end
      if (cmd.route) begin
        if (op_product) begin
          product_term <= term;
          pending_op   <= (op_code == OP_MUL) ? PEND_MUL : PEND_DIV;
        end else begin
          running_sum  <= sum_val;
          product_term <= '0;
          pending_op   <= PEND_NONE;
          if (!op_end) begin
            pending_sign <= op_code[0];
          end
        end
      end
    end
  end

  // Item capture, the iterative unit and the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_word  <= x_clamped;
      op_code <= in_item.next_operator;
    end
    if (cmd.setup) begin
      neg <= product_term[W-1] ^ x_word[W-1];
      hi  <= '0;
      if (pending_op == PEND_MUL) begin
        lo     <= NW'(mag_x);
        mcand  <= mag_pt;
        count  <= CW'(W);
        is_div <= 1'b0;
      end else if (pending_op == PEND_DIV) begin
        lo     <= NW'(mag_pt) << FRAC_BITS;
        mcand  <= mag_x;
        count  <= CW'(NW);
        is_div <= 1'b1;
        if (div_zero) begin
          term <= product_term[W-1] ? WMIN : WMAX;
        end
      end else begin
        term <= x_word;
      end
    end
    if (cmd.iter) begin
      count <= count - CW'(1);
      if (is_div) begin
        hi <= div_hi;
        lo <= {lo[NW-2:0], div_ge};
      end else begin
        hi <= add_sum[W:1];
        lo <= {add_sum[0], lo[NW-1:1]};
      end
    end
    if (cmd.sat) begin
      term <= sat_val;
    end
    if (cmd.emit) begin
      out_item.result <= fin;
      out_item.error  <= (error_seen != ERR_NONE) ? error_seen
                         : (fin_ovf ? ERR_OVERFLOW : ERR_NONE);
    end
  end

endmodule

`default_nettype wire

// File: src/fee_ctrl.sv
// Controller of the flat expression evaluator: sequences one item through
// setup, iteration, saturation and routing, and owns both handshakes.
// Depends on fee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fee_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fee_pkg::dp_cmd_t    cmd,
  input  fee_pkg::dp_status_t status
);
  import fee_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_ITER  = 6'b000100,
    S_SAT   = 6'b001000,
    S_ROUTE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  assign cmd.load  = in_valid && in_ready;
  assign cmd.setup = (state == S_SETUP);
  assign cmd.iter  = (state == S_ITER);
  assign cmd.sat   = (state == S_SAT);
  assign cmd.route = (state == S_ROUTE);
  assign cmd.emit  = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd.load) state_next = S_SETUP;
      S_SETUP: state_next = status.needs_iter ? S_ITER : S_ROUTE;
      S_ITER:  if (status.iter_last) state_next = S_SAT;
      S_SAT:   state_next = S_ROUTE;
      S_ROUTE: state_next = (!status.op_product && status.op_end) ? S_EMIT : S_IDLE;
      S_EMIT:  if (cmd.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/flat_expression_evaluator.sv
// Flat expression evaluator (+ - * / with two precedence levels), Q-format fixed point.
// Items are taken one at a time: after a transfer the item is set up, a waiting multiply
// or nonzero divide runs on the shared adder and is saturated, and the term is routed; only
// then is the next item taken. An end mark also loads the output register in an emit state,
// which waits while that register is occupied. Reset (rst, sync) clears state, out_valid.
`timescale 1ns / 1ps
`default_nettype none

module flat_expression_evaluator #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fee_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fee_pkg::out_item_t out_item
);
  import fee_pkg::*;

  // The controller accepts one item at a time. Each item first has its
  // operand saturated to the internal word. If a multiply, or a divide by a
  // nonzero operand, is waiting, the datapath loads the magnitudes into its
  // shift registers and runs a shift-add multiply or a restoring divide, one
  // bit per cycle, on the same adder that later folds terms into the running
  // sum. The magnitude is then saturated and signed to form the term.
  //
  // A multiply or divide operator parks the term as the product being built.
  // Any other operator adds or subtracts the term into the running sum. An
  // end mark (and any undefined operator code) narrows the sum to 32 bits,
  // loads the output register and clears the expression state. The output
  // register lets the result wait for its transfer while the next
  // expression starts; a second end mark waits only if that register is
  // still occupied.
  //
  // Only the first error of an expression is reported: division by zero
  // or any saturation.

  dp_cmd_t    cmd;
  dp_status_t status;

  fee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  fee_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// File: src/fee_checker.sv
// Port-level checks for the flat expression evaluator and the bind that
// attaches them to the top level. Depends on fee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fee_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input fee_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input fee_pkg::out_item_t out_item
);
  import fee_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Only the defined error codes are reported.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.error == ERR_NONE) || (out_item.error == ERR_DIV_ZERO) ||
                  (out_item.error == ERR_OVERFLOW))
    else $error("undefined error code");

  // The block works on one item at a time.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A new result appears only after the block has been busy with an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2))
    else $error("result appeared without the item being processed");

endmodule

bind flat_expression_evaluator fee_checker u_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for flat_expression_evaluator: directed and random expressions,
// a scoreboard class that predicts each expression value, and random idling on both sides.
// Depends on fee_pkg and the flat_expression_evaluator RTL.
`timescale 1ns / 1ps

module tb_top;
  import fee_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_ITEMS = 1725;
  localparam int CALM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_LIMIT = 10;

  // Operator codes above the end mark also close the expression.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // A handy Q16.16 value for the directed part.
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // The scoreboard mirrors the evaluator's expression state. Every accepted
  // input transfer advances that state; an end mark pushes the value that the
  // output side must deliver next.
  class expr_scoreboard;
    longint     running_sum = 0;
    longint     product_term = 0;
    bit         subtract_next = 1'b0;
    logic [1:0] pend_op = PEND_NONE;
    logic [1:0] first_error = ERR_NONE;
    out_item_t  expected_values[$];
    int         failures = 0;

    function void restart();
      running_sum = 0;
      product_term = 0;
      subtract_next = 1'b0;
      pend_op = PEND_NONE;
      first_error = ERR_NONE;
    endfunction

    // Only the first error of an expression is kept.
    function void flag(logic [1:0] code);
      if (first_error == ERR_NONE) first_error = code;
    endfunction

    function logic [63:0] magnitude(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // Apply a sign to a magnitude and clamp it to the 32-bit word.
    function longint saturate(bit neg, logic [127:0] mag);
      logic [127:0] limit;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > limit) begin
        flag(ERR_OVERFLOW);
        return neg ? WORD_MIN : WORD_MAX;
      end
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // Product of magnitudes, truncated by the fraction shift.
    function longint fixed_mul(longint a, longint b);
      logic [127:0] prod;
      prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      return saturate((a < 0) != (b < 0), prod >> FRAC_BITS);
    endfunction

    // Quotient of magnitudes with the dividend pre-shifted by the fraction bits.
    function longint fixed_div(longint a, longint b);
      logic [127:0] quo;
      if (b == 0) begin
        flag(ERR_DIV_ZERO);
        return (a < 0) ? WORD_MIN : WORD_MAX;
      end
      quo = ({64'd0, magnitude(a)} << FRAC_BITS) / {64'd0, magnitude(b)};
      return saturate((a < 0) != (b < 0), quo);
    endfunction

    function longint fixed_add(longint a, longint b, bit sub);
      longint s;
      s = sub ? a - b : a + b;
      return saturate(s < 0, {64'd0, magnitude(s)});
    endfunction

    function void take_operand(in_item_t it);
      longint    x;
      longint    term;
      out_item_t want;
      x = longint'(signed'(it.operand));
      case (pend_op)
        PEND_MUL: term = fixed_mul(product_term, x);
        PEND_DIV: term = fixed_div(product_term, x);
        default:  term = x;
      endcase
      if (it.next_operator == OP_MUL || it.next_operator == OP_DIV) begin
        product_term = term;
        pend_op = (it.next_operator == OP_MUL) ? PEND_MUL : PEND_DIV;
        return;
      end
      running_sum = fixed_add(running_sum, term, subtract_next);
      product_term = 0;
      pend_op = PEND_NONE;
      if (it.next_operator == OP_ADD || it.next_operator == OP_SUB) begin
        subtract_next = (it.next_operator == OP_SUB);
        return;
      end
      want.result = running_sum[31:0];
      want.error = first_error;
      expected_values.push_back(want);
      restart();
    endfunction

    function void check_value(out_item_t got);
      out_item_t want;
      if (expected_values.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result %h error %0d", $realtime, got.result, got.error);
        return;
      end
      want = expected_values.pop_front();
      if (got.result !== want.result || got.error !== want.error) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: expected result %h error %0d, got result %h error %0d",
                   $realtime, want.result, want.error, got.result, got.error);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Percent chance of starting an idle burst on each side; zero gives calm stretches.
  int in_idle_pct = 20;
  int out_idle_pct = 20;

  expr_scoreboard expr_sb = new();

  flat_expression_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Generous bound on the whole run; a hang anywhere ends here.
  initial begin
    #2_000_000;
    $display("flat_expression_evaluator: mismatch");
    $finish;
  end

  // The result side stalls in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) expr_sb.check_value(out_item);
  end

  // Present one item, possibly after an idle burst, and hold it until the
  // transfer happens. The prediction is updated at the accepting edge.
  task automatic send_item(input logic signed [31:0] value, input logic [2:0] op);
    in_item_t it;
    it.operand = value;
    it.next_operator = op;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    expr_sb.take_operand(it);
  endtask

  // Half modest values with random fractions; the rest zero, the word limits,
  // plus or minus one and fully random words so that every operand bit toggles.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? RES_MAX : RES_MIN;
      2, 3:    return $urandom;
      4:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return $urandom_range(0, 32'h007F_FFFF) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic logic [2:0] pick_closing_op();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    return OP_END;
  endfunction

  initial begin
    int items;
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: single-operand expressions at the word limits.
    send_item(RES_MAX, OP_END);
    send_item(RES_MIN, OP_END);
    // Multiply and divide with exact results, including a negative quotient.
    send_item(Q_ONE, OP_MUL);
    send_item(32'sh0002_8000, OP_END);
    send_item(-32'sh0007_0000, OP_DIV);
    send_item(32'sh0002_0000, OP_END);
    // Division by zero with a positive dividend saturates high.
    send_item(32'sh0003_0000, OP_DIV);
    send_item('0, OP_END);
    // With a negative dividend it saturates low.
    send_item(-32'sh0003_0000, OP_DIV);
    send_item('0, OP_END);
    // Zero divided by zero, then overflows: only the first error survives.
    send_item('0, OP_DIV);
    send_item('0, OP_ADD);
    send_item(RES_MAX, OP_MUL);
    send_item(RES_MAX, OP_END);
    // The sum overflows upward, then downward through a subtraction.
    send_item(RES_MAX, OP_ADD);
    send_item(32'sd1, OP_END);
    send_item(RES_MIN, OP_SUB);
    send_item(32'sd1, OP_RSVD5);
    // Precedence: 2 + 3 * 4 - 8 / 2 gives 10.
    send_item(32'sh0002_0000, OP_ADD);
    send_item(32'sh0003_0000, OP_MUL);
    send_item(32'sh0004_0000, OP_SUB);
    send_item(32'sh0008_0000, OP_DIV);
    send_item(32'sh0002_0000, OP_RSVD6);
    send_item(Q_ONE, OP_RSVD7);

    // Random expressions of mostly short length, occasionally long chains.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items >= RANDOM_ITEMS - CALM_ITEMS) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 2))
          0:       begin in_idle_pct = 0;  out_idle_pct = 0;  end
          1:       begin in_idle_pct = 15; out_idle_pct = 15; end
          default: begin in_idle_pct = 50; out_idle_pct = 50; end
        endcase
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if (k == len - 1) send_item(pick_operand(), pick_closing_op());
        else send_item(pick_operand(), 3'($urandom_range(OP_ADD, OP_DIV)));
        items++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted value, then a little longer for strays.
    while (expr_sb.expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expr_sb.failures == 0) begin
      $display("flat_expression_evaluator: match");
    end else begin
      $display("flat_expression_evaluator: mismatch");
    end
    $finish;
  end

endmodule

// File: flat_expression_evaluator.f
src/fee_pkg.sv
src/fee_datapath.sv
src/fee_ctrl.sv
src/flat_expression_evaluator.sv
src/fee_checker.sv
tb/tb_top.sv
